FILE: design/stm_pkg.sv
// stm_pkg: shared types, sizes, command and status codes of the sorted term table
// depends on nothing; every other file of the block refers to it by scoped names
package stm_pkg;

	localparam int CAPACITY    = 32;
	localparam int DEGREE_BITS = 16;
	localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W       = $clog2(CAPACITY + 1);

	localparam logic [7:0] VAR_RESET = 8'd120;

	// command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DUMP   = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	// result status codes
	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_MERGED   = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_TERM     = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;
	localparam logic [2:0] ST_CLEARED  = 3'd5;

	typedef struct packed {
		logic [DEGREE_BITS-1:0] degree;
		logic [31:0]            coeff;
		logic [7:0]             variable;
	} entry_t;

	typedef struct packed {
		logic [2:0]             status;
		logic [DEGREE_BITS-1:0] degree;
		logic [31:0]            coeff;
		logic [7:0]             variable;
		logic                   last;
	} res_t;

	typedef struct packed {
		logic        gt;
		logic        eq;
		logic [31:0] sum;
	} alu_t;

	function automatic logic [DEGREE_BITS-1:0] deg_in(input logic [15:0] d);
		logic [47:0] w;
		w = 48'(d);
		return w[DEGREE_BITS-1:0];
	endfunction

	function automatic logic [15:0] deg_out(input logic [DEGREE_BITS-1:0] d);
		logic [47:0] w;
		w = 48'(d);
		return w[15:0];
	endfunction

endpackage

FILE: design/stm_table_ram.sv
// stm_table_ram: term store, one write port and one read port with registered read data
// depends on stm_pkg for the entry type and depth
module stm_table_ram (
	input  logic                  clk,
	input  logic                  we,
	input  logic [stm_pkg::IDX_W-1:0] waddr,
	input  stm_pkg::entry_t       wdata,
	input  logic [stm_pkg::IDX_W-1:0] raddr,
	output stm_pkg::entry_t       rdata
);

	stm_pkg::entry_t mem_q [stm_pkg::CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/stm_alu.sv
// stm_alu: shared degree comparator and 32-bit wrapping coefficient adder
// depends on stm_pkg for widths and the result type
module stm_alu (
	input  logic [stm_pkg::DEGREE_BITS-1:0] stored_degree,
	input  logic [stm_pkg::DEGREE_BITS-1:0] new_degree,
	input  logic [31:0]                     stored_coeff,
	input  logic [31:0]                     new_coeff,
	output stm_pkg::alu_t                   result
);

	always_comb begin
		result.gt  = stored_degree > new_degree;
		result.eq  = stored_degree == new_degree;
		result.sum = stored_coeff + new_coeff;
	end

endmodule

FILE: design/stm_seq.sv
// stm_seq: sequencer that walks, shifts, merges and reads out the term store
// depends on stm_pkg, stm_table_ram and stm_alu
module stm_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            idle,
	input  logic [1:0]                      cmd,
	input  logic [stm_pkg::DEGREE_BITS-1:0] degree,
	input  logic [31:0]                     coeff,
	input  logic [7:0]                      var_code,
	input  logic                            can_emit,
	output logic                            emit,
	output stm_pkg::res_t                   res,
	output logic [stm_pkg::CNT_W-1:0]       term_count
);

	localparam int CW = stm_pkg::CNT_W;
	localparam int IW = stm_pkg::IDX_W;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_SHIFT  = 3'd2;
	localparam logic [2:0] S_INSERT = 3'd3;
	localparam logic [2:0] S_MERGE  = 3'd4;
	localparam logic [2:0] S_EMIT   = 3'd5;
	localparam logic [2:0] S_DUMP   = 3'd6;

	logic [2:0]                      state_q, state_d;
	logic [CW-1:0]                   count_q, count_d;
	logic [CW-1:0]                   pos_q, pos_d;
	logic [IW-1:0]                   src_q, src_d;
	logic [IW-1:0]                   idx_q, idx_d;
	logic [stm_pkg::DEGREE_BITS-1:0] deg_q, deg_d;
	logic [31:0]                     coeff_q, coeff_d;
	stm_pkg::res_t                   res_q, res_d;

	logic            we;
	logic [IW-1:0]   waddr;
	logic [IW-1:0]   raddr;
	stm_pkg::entry_t wdata;
	stm_pkg::entry_t rdata;
	stm_pkg::alu_t   alu;
	logic            pos_in;
	logic            dump_last;

	stm_table_ram u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	stm_alu u_alu (
		.stored_degree (rdata.degree),
		.new_degree    (deg_q),
		.stored_coeff  (rdata.coeff),
		.new_coeff     (coeff_q),
		.result        (alu)
	);

	assign pos_in    = pos_q < count_q;
	assign dump_last = (CW'(idx_q) + CW'(1)) == count_q;

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		pos_d   = pos_q;
		src_d   = src_q;
		idx_d   = idx_q;
		deg_d   = deg_q;
		coeff_d = coeff_q;
		res_d   = res_q;
		raddr   = '0;
		we      = 1'b0;
		waddr   = IW'(pos_q);
		wdata   = '{degree: deg_q, coeff: coeff_q, variable: var_code};
		emit    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					deg_d   = degree;
					coeff_d = coeff;
					pos_d   = '0;
					idx_d   = '0;
					case (cmd)
						stm_pkg::CMD_INSERT: begin
							state_d = S_SEARCH;
						end
						stm_pkg::CMD_DUMP: begin
							if (count_q == '0) begin
								res_d   = '{stm_pkg::ST_EMPTY, '0, '0, '0, 1'b1};
								state_d = S_EMIT;
							end else begin
								state_d = S_DUMP;
							end
						end
						stm_pkg::CMD_CLEAR: begin
							count_d = '0;
							res_d   = '{stm_pkg::ST_CLEARED, '0, '0, '0, 1'b1};
							state_d = S_EMIT;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_SEARCH: begin
				if (pos_in && alu.gt) begin
					pos_d = pos_q + CW'(1);
					raddr = IW'(pos_q + CW'(1));
				end else if (pos_in && alu.eq) begin
					res_d   = '{stm_pkg::ST_MERGED, deg_q, alu.sum, rdata.variable, 1'b1};
					state_d = S_MERGE;
				end else if (count_q == CW'(stm_pkg::CAPACITY)) begin
					res_d   = '{stm_pkg::ST_FULL, deg_q, coeff_q, var_code, 1'b1};
					state_d = S_EMIT;
				end else if (pos_in) begin
					src_d   = IW'(count_q - CW'(1));
					raddr   = IW'(count_q - CW'(1));
					state_d = S_SHIFT;
				end else begin
					state_d = S_INSERT;
				end
			end
			S_SHIFT: begin
				we    = 1'b1;
				waddr = src_q + IW'(1);
				wdata = rdata;
				if (CW'(src_q) == pos_q) begin
					state_d = S_INSERT;
				end else begin
					src_d = src_q - IW'(1);
					raddr = src_q - IW'(1);
				end
			end
			S_INSERT: begin
				we      = 1'b1;
				count_d = count_q + CW'(1);
				res_d   = '{stm_pkg::ST_INSERTED, deg_q, coeff_q, var_code, 1'b1};
				state_d = S_EMIT;
			end
			S_MERGE: begin
				we      = 1'b1;
				wdata   = '{degree: deg_q, coeff: res_q.coeff, variable: res_q.variable};
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (can_emit) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_DUMP: begin
				raddr = idx_q;
				if (can_emit) begin
					emit = 1'b1;
					if (dump_last) begin
						state_d = S_IDLE;
					end else begin
						idx_d = idx_q + IW'(1);
						raddr = idx_q + IW'(1);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q   <= pos_d;
		src_q   <= src_d;
		idx_q   <= idx_d;
		deg_q   <= deg_d;
		coeff_q <= coeff_d;
		res_q   <= res_d;
	end

	always_comb begin
		if (state_q == S_DUMP) begin
			res = '{stm_pkg::ST_TERM, rdata.degree, rdata.coeff, rdata.variable, dump_last};
		end else begin
			res = res_q;
		end
	end

	assign idle       = state_q == S_IDLE;
	assign term_count = count_q;

endmodule

FILE: design/sorted_term_table_merge_insert_unit.sv
// sorted_term_table_merge_insert_unit: top level, config register, result register, checks
// depends on stm_pkg and stm_seq
//
// channel   direction  contents (lowest bit first)
// s_*       request    tuser: cmd[1:0]; tdata: term_degree[15:0], term_coeff[47:16]
// m_*       result     tuser: status[2:0]; tdata: out_degree, out_coeff, out_variable,
//                      count, zero pad; tlast: last
// cfg_*     config     data: variable_code[7:0]
//
// one request at a time; s_tready is high only while the sequencer is idle
// insert: walks to the slot, then shifts the tail one entry a cycle through the single
//   read and single write port of the term store
// reset clears the control state and the term count; the store itself is not swept
// a stalled result holds in the output register; the read-out pauses with it
module sorted_term_table_merge_insert_unit (
	input  logic        clk,
	input  logic        arst_n,
	// request side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // term_degree[15:0], term_coeff[47:16]
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	// result side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // out_degree[15:0], out_coeff[47:16],
	                               // out_variable[55:48], count[61:56], zero[63:62]
	output logic [2:0]  m_tuser,   // status[2:0]
	output logic        m_tlast,   // last
	// configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data   // variable_code[7:0]
);

	logic [7:0]                    var_code_q;
	logic                          seq_idle;
	logic                          start;
	logic                          can_emit;
	logic                          emit;
	stm_pkg::res_t                 res;
	logic [stm_pkg::CNT_W-1:0]     term_count;

	logic                          m_tvalid_q;
	logic [63:0]                   m_tdata_q;
	logic [2:0]                    m_tuser_q;
	logic                          m_tlast_q;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_code_q <= stm_pkg::VAR_RESET;
		end else if (cfg_valid) begin
			var_code_q <= cfg_data;
		end
	end

	assign s_tready = seq_idle;
	assign start    = s_tvalid && seq_idle;
	// the result register is free, or it is being emptied this cycle
	assign can_emit = !m_tvalid_q || m_tready;

	stm_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.idle       (seq_idle),
		.cmd        (s_tuser),
		.degree     (stm_pkg::deg_in(s_tdata[15:0])),
		.coeff      (s_tdata[47:16]),
		.var_code   (var_code_q),
		.can_emit   (can_emit),
		.emit       (emit),
		.res        (res),
		.term_count (term_count)
	);

	// result register: count is taken after this step's update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata_q <= {2'b00, 6'(term_count), res.variable, res.coeff,
				stm_pkg::deg_out(res.degree)};
			m_tuser_q <= res.status;
			m_tlast_q <= res.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

`ifndef SYNTHESIS
	// the table never holds more terms than it has room for
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		term_count <= stm_pkg::CAPACITY)
		else $error("term count beyond capacity");

	// a result is only loaded when the output register can take it
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!m_tvalid_q || m_tready))
		else $error("result loaded over a waiting one");

	// an accepted clear empties the table at once
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == stm_pkg::CMD_CLEAR) |=> term_count == '0)
		else $error("clear left terms behind");

	// no new request is taken while a result is being produced
	a_busy_no_start: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !s_tready || $past(s_tvalid && s_tready) || !m_tvalid)
		else $error("request accepted while producing a result");
`endif

endmodule
